@@ rtl/core/cfrc_pkg.sv @@
// cfrc_pkg: shared constants and types for the cobs frame receiver with crc-8 check
// used by every module in rtl/core and by the port checker
// no dependencies
`default_nettype none

package cfrc_pkg;

   localparam int          PACKET_LEN_DEF = 8;
   localparam int          CNT_W          = 6;
   localparam int          POS_W          = 5;
   localparam int          INDEX_W        = 5;
   localparam logic [7:0]  CRC_POLY       = 8'h31;
   localparam logic [7:0]  CODE_FULL      = 8'hFF;
   localparam logic [7:0]  FRAME_DELIM    = 8'h00;
   localparam logic [POS_W-1:0] CRC_POS_RESET = 5'd7;
   localparam logic [CNT_W-1:0] CNT_MAX   = 6'd63;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_LEN_ERR = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/cfrc_crc8_serial.sv @@
// cfrc_crc8_serial: bit-serial crc-8 unit, one polynomial step per cycle
// holds the running checksum of the current frame
// depends on cfrc_pkg
`default_nettype none

module cfrc_crc8_serial
   import cfrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       clear,
   input  wire logic [7:0] din,
   output logic      [7:0] crc,
   output logic            busy
);

   logic [7:0] crc_ff, crc_in;
   logic [2:0] step_ff, step_in;
   logic       busy_ff, busy_in;

   always_comb begin
      crc_in  = crc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         // one msb-first shift per cycle
         if (crc_ff[7]) begin
            crc_in = {crc_ff[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc_in = {crc_ff[6:0], 1'b0};
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end else if (clear) begin
         crc_in = '0;
      end else if (start) begin
         crc_in  = crc_ff ^ din;
         step_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= '0;
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/core/cobs_frame_receiver_crc8.sv @@
// channel   | ports                        | direction | beat carries
// req       | req_valid/req_ready          | in        | req_rx_byte
// rsp       | rsp_valid/rsp_ready          | out       | data_byte, byte_index, last, status
// csr       | csr_wr_en/csr_wr_data        | in        | crc_position, no wait
//
// a nonzero byte that commits a decoded byte below PACKET_LEN holds req_ready low while the
// bit-serial crc unit steps through it; other bytes do not wait on the crc unit
// a frame end with the right length and a good checksum gives PACKET_LEN beats, each passing
// ST_RD then ST_EMIT, paced by the registered read of the packet store
// synchronous reset returns the frame state and crc_position (7); store is not cleared
// rsp stalls hold the output register; req is taken again once the last beat is loaded
`default_nettype none

module cobs_frame_receiver_crc8
   import cfrc_pkg::*;
#(
   parameter int PACKET_LEN = PACKET_LEN_DEF
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_data_byte,
   output logic [INDEX_W-1:0]      rsp_byte_index,
   output logic                    rsp_last,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_wr_en,
   input  wire logic [POS_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (PACKET_LEN > 1) ? $clog2(PACKET_LEN) : 1;
   localparam logic [CNT_W-1:0] PLEN_CNT  = CNT_W'(PACKET_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PACKET_LEN - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RD   = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_ERR  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] crc_pos_ff;
   logic [7:0]       group_left_ff, group_left_in;
   logic             zero_pend_ff, zero_pend_in;
   logic [CNT_W-1:0] enc_cnt_ff, enc_cnt_in;
   logic [CNT_W-1:0] dec_cnt_ff, dec_cnt_in;
   logic [7:0]       rx_crc_ff, rx_crc_in;
   logic [IDX_W-1:0] emit_idx_ff, emit_idx_in;
   status_type       err_status_ff, err_status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_last_ff, rsp_last_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic [7:0]       packet_store [PACKET_LEN];
   logic [7:0]       rd_data_ff;

   logic             accept, slot_free, frame_end;
   logic             commit, commit_stored;
   logic [7:0]       commit_val;
   logic             crc_start, crc_busy;
   logic [7:0]       crc_din, crc_value;

   cfrc_crc8_serial u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .clear (frame_end),
      .din   (crc_din),
      .crc   (crc_value),
      .busy  (crc_busy)
   );

   assign req_ready = (state_ff == ST_IDLE) && !crc_busy;
   assign accept    = req_valid && req_ready;
   assign frame_end = accept && (req_rx_byte == FRAME_DELIM);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // cobs decode of one nonzero byte
   always_comb begin
      commit     = 1'b0;
      commit_val = req_rx_byte;
      if (group_left_ff != 8'd0) begin
         commit = 1'b1;
      end else if (zero_pend_ff) begin
         commit     = 1'b1;
         commit_val = 8'd0;
      end
   end

   assign commit_stored = accept && !frame_end && commit && (dec_cnt_ff < PLEN_CNT);
   assign crc_start     = commit_stored;
   // checksum byte enters the crc as zero
   assign crc_din = (dec_cnt_ff == CNT_W'(crc_pos_ff)) ? 8'd0 : commit_val;

   always_comb begin
      state_in      = state_ff;
      group_left_in = group_left_ff;
      zero_pend_in  = zero_pend_ff;
      enc_cnt_in    = enc_cnt_ff;
      dec_cnt_in    = dec_cnt_ff;
      rx_crc_in     = rx_crc_ff;
      emit_idx_in   = emit_idx_ff;
      err_status_in = err_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (frame_end) begin
               if (enc_cnt_ff > CNT_W'(1)) begin
                  if (dec_cnt_ff != PLEN_CNT) begin
                     err_status_in = STATUS_LEN_ERR;
                     state_in      = ST_ERR;
                  end else if (crc_value != rx_crc_ff) begin
                     err_status_in = STATUS_CRC_ERR;
                     state_in      = ST_ERR;
                  end else begin
                     emit_idx_in = '0;
                     state_in    = ST_RD;
                  end
               end
               group_left_in = '0;
               zero_pend_in  = 1'b0;
               enc_cnt_in    = '0;
               dec_cnt_in    = '0;
               rx_crc_in     = '0;
            end else if (accept) begin
               if (enc_cnt_ff != CNT_MAX) begin
                  enc_cnt_in = enc_cnt_ff + CNT_W'(1);
               end
               if (group_left_ff != 8'd0) begin
                  group_left_in = group_left_ff - 8'd1;
               end else begin
                  group_left_in = req_rx_byte - 8'd1;
                  zero_pend_in  = (req_rx_byte != CODE_FULL);
               end
               if (commit) begin
                  if (dec_cnt_ff != CNT_MAX) begin
                     dec_cnt_in = dec_cnt_ff + CNT_W'(1);
                  end
                  if (commit_stored && (dec_cnt_ff == CNT_W'(crc_pos_ff))) begin
                     rx_crc_in = commit_val;
                  end
               end
            end
         end
         ST_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_data_ff;
               rsp_index_in  = INDEX_W'(emit_idx_ff);
               rsp_last_in   = (emit_idx_ff == LAST_IDX);
               rsp_status_in = STATUS_OK;
               if (emit_idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + IDX_W'(1);
                  state_in    = ST_RD;
               end
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = err_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         crc_pos_ff    <= CRC_POS_RESET;
         group_left_ff <= '0;
         zero_pend_ff  <= 1'b0;
         enc_cnt_ff    <= '0;
         dec_cnt_ff    <= '0;
         rx_crc_ff     <= '0;
         emit_idx_ff   <= '0;
         err_status_ff <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            crc_pos_ff <= csr_wr_data;
         end
         group_left_ff <= group_left_in;
         zero_pend_ff  <= zero_pend_in;
         enc_cnt_ff    <= enc_cnt_in;
         dec_cnt_ff    <= dec_cnt_in;
         rx_crc_ff     <= rx_crc_in;
         emit_idx_ff   <= emit_idx_in;
         err_status_ff <= err_status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // packet store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (commit_stored) begin
         packet_store[dec_cnt_ff[IDX_W-1:0]] <= commit_val;
      end
      rd_data_ff <= packet_store[emit_idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/core/cfrc_checker.sv @@
// cfrc_checker: port-level assertions for cobs_frame_receiver_crc8, bound to the top level
// depends on cfrc_pkg and cobs_frame_receiver_crc8
`default_nettype none

module cfrc_checker
   import cfrc_pkg::*;
#(
   parameter int PACKET_LEN = PACKET_LEN_DEF
)(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [7:0]         rsp_data_byte,
   input wire logic [INDEX_W-1:0] rsp_byte_index,
   input wire logic               rsp_last,
   input wire logic [1:0]         rsp_status
);

   // error beats are single-beat frames with zeroed payload
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         rsp_last && (rsp_data_byte == 8'd0) && (rsp_byte_index == '0))
      else $error("error beat with payload or without last");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_CRC_ERR)
                    || (rsp_status == STATUS_LEN_ERR))
      else $error("unknown status code");

   // a packet run ends at the last packet position
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |->
         (rsp_last == (rsp_byte_index == INDEX_W'(PACKET_LEN - 1))))
      else $error("last flag does not match packet end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_data_byte) && $stable(rsp_byte_index)
         && $stable(rsp_last) && $stable(rsp_status))
      else $error("stalled rsp beat changed");

   // first cycle out of reset: nothing to send, ready to take a byte
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("rsp valid or req stalled right after reset");

endmodule

bind cobs_frame_receiver_crc8 cfrc_checker #(.PACKET_LEN(PACKET_LEN)) u_cfrc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_byte_index (rsp_byte_index),
   .rsp_last       (rsp_last),
   .rsp_status     (rsp_status)
);

`default_nettype wire
